### rtl/rec_pkg.sv
package rec_pkg;

    localparam int unsigned TICK_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned EV_W   = 3;
    localparam int unsigned IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd50;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_DOUBLE_CLICK = 16'd300;

    localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EV_W-1:0] EV_CW     = 3'd1;
    localparam logic [EV_W-1:0] EV_CCW    = 3'd2;
    localparam logic [EV_W-1:0] EV_CLICK  = 3'd3;
    localparam logic [EV_W-1:0] EV_DOUBLE = 3'd4;
    localparam logic [EV_W-1:0] EV_LONG   = 3'd5;

    localparam logic [1:0] CLICK_MAX = 2'd3;

    typedef struct packed {
        logic encoder_a;
        logic encoder_b;
        logic switch_level;
        logic read_strobe;
        logic clear_strobe;
    } t_in;

    typedef struct packed {
        logic [EV_W-1:0]         event_code;
        logic                    rotation_pending;
        logic signed [POS_W-1:0] position_count;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] double_click_ticks;
    } t_cfg;

endpackage

### rtl/rec_core.sv
module rec_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  rec_pkg::t_in  i_item,
    input  rec_pkg::t_cfg i_cfg,
    output rec_pkg::t_out o_result
);
    import rec_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic              r_last_a;
    logic              r_last_sw;
    logic              r_press_active;
    logic              r_lps;
    logic [1:0]        r_clicks;
    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] r_deb_stamp;
    logic [TICK_W-1:0] r_press_stamp;
    logic [TICK_W-1:0] r_rel_stamp;
    logic [EV_W-1:0]   r_event;

    logic [POS_W-1:0]  n_pos;
    logic [1:0]        n_clicks;
    logic [EV_W-1:0]   n_event;
    logic              n_press_active;
    logic              n_lps;

    logic              a_rise;
    logic              sw_accept;
    logic              press_now;
    logic              rel_now;
    logic              click_now;
    logic              long_hit;
    logic              click_hit;
    logic              pa1;
    logic              lps1;
    logic [1:0]        cc1;
    logic [1:0]        cc2;
    logic [EV_W-1:0]   ev1;
    logic [EV_W-1:0]   ev2;
    logic [EV_W-1:0]   ev3;
    logic [TICK_W-1:0] deb_age;
    logic [TICK_W-1:0] press_age;
    logic [TICK_W-1:0] rel_age;

    always_comb begin
        a_rise = i_item.encoder_a & ~r_last_a;
        n_pos  = r_pos;
        ev1    = r_event;
        if (a_rise) begin
            if (i_item.encoder_b != i_item.encoder_a) begin
                n_pos = r_pos + POS_W'(1);
                ev1   = EV_CW;
            end else begin
                n_pos = r_pos - POS_W'(1);
                ev1   = EV_CCW;
            end
        end

        deb_age   = r_tick - r_deb_stamp;
        press_age = r_tick - r_press_stamp;
        rel_age   = r_tick - r_rel_stamp;

        sw_accept = (i_item.switch_level != r_last_sw)
                    && (deb_age >= {{(TICK_W-CFG_W){1'b0}}, i_cfg.debounce_ticks});
        press_now = sw_accept & ~i_item.switch_level;
        rel_now   = sw_accept & i_item.switch_level;
        click_now = rel_now & r_press_active & ~r_lps;

        pa1  = press_now ? 1'b1 : (rel_now ? 1'b0 : r_press_active);
        lps1 = press_now ? 1'b0 : r_lps;
        cc1  = (click_now && r_clicks != CLICK_MAX) ? r_clicks + 2'd1 : r_clicks;

        // a press that starts this tick has zero age
        long_hit = pa1 & ~lps1 & ~press_now
                   & (press_age > {{(TICK_W-CFG_W){1'b0}}, i_cfg.long_press_ticks});
        n_press_active = long_hit ? 1'b0 : pa1;
        n_lps          = long_hit ? 1'b1 : lps1;
        cc2            = long_hit ? 2'd0 : cc1;
        ev2            = long_hit ? EV_LONG : ev1;

        // a release stamped this tick has zero age
        click_hit = (cc2 != 2'd0) & ~click_now
                    & (rel_age > {{(TICK_W-CFG_W){1'b0}}, i_cfg.double_click_ticks});
        ev3 = click_hit ? ((cc2 == 2'd1) ? EV_CLICK : EV_DOUBLE) : ev2;

        n_clicks = (click_hit || i_item.clear_strobe) ? 2'd0 : cc2;
        n_event  = (i_item.read_strobe || i_item.clear_strobe) ? EV_NONE : ev3;

        o_result.event_code       = ev3;
        o_result.rotation_pending = (ev3 == EV_CW) || (ev3 == EV_CCW);
        o_result.position_count   = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_last_a       <= 1'b0;
            r_last_sw      <= 1'b1;
            r_press_active <= 1'b0;
            r_lps          <= 1'b0;
            r_clicks       <= '0;
            r_tick         <= '0;
            r_deb_stamp    <= '0;
            r_press_stamp  <= '0;
            r_rel_stamp    <= '0;
            r_event        <= EV_NONE;
        end else if (i_step) begin
            r_pos          <= i_item.clear_strobe ? '0 : n_pos;
            r_last_a       <= i_item.encoder_a;
            r_last_sw      <= i_item.switch_level;
            r_press_active <= n_press_active;
            r_lps          <= n_lps;
            r_clicks       <= n_clicks;
            r_tick         <= r_tick + TICK_W'(1);
            r_event        <= n_event;
            if (sw_accept) begin
                r_deb_stamp <= r_tick;
            end
            if (press_now) begin
                r_press_stamp <= r_tick;
            end
            if (click_now) begin
                r_rel_stamp <= r_tick;
            end
        end
    end

`ifndef SYNTHESIS
    a_clicks_no_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clicks != 2'd0) |-> !r_lps)
        else $error("click count pending after long press");

    a_press_no_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press_active |-> !r_lps)
        else $error("press active with long press seen");

    a_clear_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.clear_strobe) |=> (r_pos == '0 && r_clicks == 2'd0
                                             && r_event == EV_NONE))
        else $error("clear did not zero state");

    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_tick))
        else $error("tick moved without an item");
`endif

endmodule

### rtl/rotary_encoder_click_detector.sv
// Items pass the input register, combinational rule logic, then the result register.
// Throughput: 1 item per cycle unless the output stalls.
// Exactly one result per input item.
// Reset (i_rst_n low, synchronous): registers to 50/1000/300, position and counters
// zeroed, switch seen as released, no event pending, both stages empty.
module rotary_encoder_click_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rec_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rec_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [rec_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [rec_pkg::CFG_W-1:0]   i_cfg_data
);
    import rec_pkg::*;

    t_cfg r_cfg;
    t_in  r_in;
    logic r_in_valid;
    t_out r_out;
    logic r_out_valid;
    t_out result;
    logic out_free;
    logic step;
    logic in_xfer;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    rec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= RST_DEBOUNCE;
            r_cfg.long_press_ticks   <= RST_LONG_PRESS;
            r_cfg.double_click_ticks <= RST_DOUBLE_CLICK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:     r_cfg.debounce_ticks     <= i_cfg_data;
                CFG_LONG_PRESS:   r_cfg.long_press_ticks   <= i_cfg_data;
                CFG_DOUBLE_CLICK: r_cfg.double_click_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (step) begin
            r_out <= result;
        end
    end

`ifndef SYNTHESIS
    a_rot_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.rotation_pending) |->
            (o_out_data.event_code == EV_CW || o_out_data.event_code == EV_CCW))
        else $error("rotation flag without rotation event");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in)))
        else $error("held input item lost");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rec_pkg::*;

    localparam int unsigned LIMIT     = 1_000_000;
    localparam int          MAX_SHOWN = 10;

    typedef struct packed {
        logic             is_cfg;
        t_in              pins;
        logic [15:0]      reps;
        logic             fixed;
        t_out             want;
        logic [CFG_W-1:0] db;
        logic [CFG_W-1:0] lp;
        logic [CFG_W-1:0] dc;
    } t_script_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out             o_out_data;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    // detector state as predicted
    logic [CFG_W-1:0]  m_debounce;
    logic [CFG_W-1:0]  m_long;
    logic [CFG_W-1:0]  m_double;
    logic [POS_W-1:0]  m_pos;
    logic              m_last_a;
    logic              m_last_sw;
    logic              m_pressed;
    logic              m_long_seen;
    logic [1:0]        m_clicks;
    logic [TICK_W-1:0] m_now;
    logic [TICK_W-1:0] m_db_stamp;
    logic [TICK_W-1:0] m_press_stamp;
    logic [TICK_W-1:0] m_rel_stamp;
    logic [EV_W-1:0]   m_event;

    // random tick source
    logic gen_sw;
    logic gen_a;
    logic gen_dir;
    int   gen_hold;

    t_out          pending_reports[$];
    t_out          oldest_report;
    t_script_row   script[$];
    bit            quiet_run = 1'b0;
    int            errors = 0;
    int unsigned   cycles = 0;

    rotary_encoder_click_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic t_out next_report(t_in it);
        t_out r;
        if (it.encoder_a && !m_last_a) begin
            if (it.encoder_b != it.encoder_a) begin
                m_pos   = m_pos + 1'b1;
                m_event = EV_CW;
            end else begin
                m_pos   = m_pos - 1'b1;
                m_event = EV_CCW;
            end
        end
        m_last_a = it.encoder_a;

        if (it.switch_level != m_last_sw &&
            (m_now - m_db_stamp) >= {16'd0, m_debounce}) begin
            m_db_stamp = m_now;
            if (!it.switch_level) begin
                m_pressed     = 1'b1;
                m_press_stamp = m_now;
                m_long_seen   = 1'b0;
            end else begin
                if (m_pressed && !m_long_seen) begin
                    if (m_clicks != CLICK_MAX) m_clicks = m_clicks + 2'd1;
                    m_rel_stamp = m_now;
                end
                m_pressed = 1'b0;
            end
        end
        m_last_sw = it.switch_level;

        if (m_pressed && !m_long_seen && (m_now - m_press_stamp) > {16'd0, m_long}) begin
            m_event     = EV_LONG;
            m_long_seen = 1'b1;
            m_clicks    = 2'd0;
            m_pressed   = 1'b0;
        end

        if (m_clicks != 2'd0 && (m_now - m_rel_stamp) > {16'd0, m_double}) begin
            m_event  = (m_clicks == 2'd1) ? EV_CLICK : EV_DOUBLE;
            m_clicks = 2'd0;
        end

        r.event_code       = m_event;
        r.rotation_pending = (m_event == EV_CW || m_event == EV_CCW);
        r.position_count   = m_pos;

        if (it.read_strobe) m_event = EV_NONE;
        if (it.clear_strobe) begin
            m_event  = EV_NONE;
            m_clicks = 2'd0;
            m_pos    = '0;
        end
        m_now = m_now + 1'b1;
        return r;
    endfunction

    function automatic t_script_row tick_row(logic [4:0] pins, int n);
        t_script_row r;
        r      = '0;
        r.pins = pins;
        r.reps = n[15:0];
        return r;
    endfunction

    function automatic t_script_row tick_row_chk(logic [4:0] pins, t_out w);
        t_script_row r;
        r       = tick_row(pins, 1);
        r.fixed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    function automatic t_script_row cfg_row(logic [CFG_W-1:0] db, lp, dc);
        t_script_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.db     = db;
        r.lp     = lp;
        r.dc     = dc;
        return r;
    endfunction

    // switch hold lengths clustered round the configured thresholds
    function automatic int pick_hold();
        int h;
        case ($urandom_range(9))
            0, 1:    h = $urandom_range(1, 2);
            2, 3, 4: h = int'(m_debounce) + $urandom_range(1, 4);
            5, 6:    h = int'(m_double) + $urandom_range(0, 3);
            7:       h = int'(m_long) + $urandom_range(1, 3);
            default: h = $urandom_range(1, 3 * int'(m_debounce) + 8);
        endcase
        if (h > 1500) h = 1500;
        return h;
    endfunction

    task automatic push_tick(input t_in it, input logic fixed, input t_out fixed_want);
        t_out w;
        while (!quiet_run && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        w = next_report(it);
        pending_reports.push_back(fixed ? fixed_want : w);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] db, lp, dc);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= db;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG_PRESS;
        i_cfg_data <= lp;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DOUBLE_CLICK;
        i_cfg_data <= dc;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        m_debounce = db;
        m_long     = lp;
        m_double   = dc;
    endtask

    task automatic run_phase(input int n_items);
        t_in it;
        repeat (n_items) begin
            if (gen_hold == 0) begin
                gen_sw   = !gen_sw;
                gen_hold = pick_hold();
            end
            gen_hold = gen_hold - 1;
            if ($urandom_range(2) == 0) gen_a = !gen_a;
            if ($urandom_range(19) == 0) gen_dir = !gen_dir;
            it.encoder_a    = gen_a;
            it.encoder_b    = gen_a ^ gen_dir;
            if ($urandom_range(15) == 0) it.encoder_b = 1'($urandom_range(1));
            it.switch_level = gen_sw;
            if ($urandom_range(39) == 0) it.switch_level = !gen_sw;
            it.read_strobe  = ($urandom_range(7) == 0);
            it.clear_strobe = ($urandom_range(59) == 0);
            push_tick(it, 1'b0, '0);
        end
    endtask

    // run of detents in one direction after a clear
    task automatic spin(input logic cw, input int detents);
        t_in it;
        it              = '0;
        it.switch_level = 1'b1;
        it.clear_strobe = 1'b1;
        push_tick(it, 1'b0, '0);
        it.clear_strobe = 1'b0;
        repeat (detents) begin
            it.encoder_a   = 1'b1;
            it.encoder_b   = !cw;
            it.read_strobe = ($urandom_range(3) == 0);
            push_tick(it, 1'b0, '0);
            it.encoder_a   = 1'b0;
            push_tick(it, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !quiet_run && ($urandom_range(99) < 6);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected transfer: ev %0d rot %0b pos %0d",
                             o_out_data.event_code, o_out_data.rotation_pending,
                             o_out_data.position_count);
            end else begin
                oldest_report = pending_reports.pop_front();
                if (o_out_data.event_code !== oldest_report.event_code ||
                    o_out_data.rotation_pending !== oldest_report.rotation_pending ||
                    o_out_data.position_count !== oldest_report.position_count) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display({"mismatch: exp ev %0d rot %0b pos %0d,",
                                  " got ev %0d rot %0b pos %0d"},
                                 oldest_report.event_code, oldest_report.rotation_pending,
                                 oldest_report.position_count, o_out_data.event_code,
                                 o_out_data.rotation_pending, o_out_data.position_count);
                end
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= '0;

        m_debounce    = RST_DEBOUNCE;
        m_long        = RST_LONG_PRESS;
        m_double      = RST_DOUBLE_CLICK;
        m_pos         = '0;
        m_last_a      = 1'b0;
        m_last_sw     = 1'b1;
        m_pressed     = 1'b0;
        m_long_seen   = 1'b0;
        m_clicks      = 2'd0;
        m_now         = '0;
        m_db_stamp    = '0;
        m_press_stamp = '0;
        m_rel_stamp   = '0;
        m_event       = EV_NONE;
        gen_sw        = 1'b1;
        gen_a         = 1'b0;
        gen_dir       = 1'b1;
        gen_hold      = 0;

        // pins: a b sw rd clr
        script = '{
            tick_row_chk(5'b00100, t_out'{EV_NONE, 1'b0, 16'sd0}),
            tick_row_chk(5'b10100, t_out'{EV_CW, 1'b1, 16'sd1}),
            tick_row_chk(5'b00110, t_out'{EV_CW, 1'b1, 16'sd1}),
            tick_row_chk(5'b11100, t_out'{EV_CCW, 1'b1, 16'sd0}),
            tick_row_chk(5'b01101, t_out'{EV_CCW, 1'b1, 16'sd0}),
            tick_row_chk(5'b11100, t_out'{EV_CCW, 1'b1, -16'sd1}),
            tick_row(5'b01000, 1),      // press inside debounce window, dropped
            tick_row(5'b00100, 1),
            tick_row_chk(5'b10111, t_out'{EV_CW, 1'b1, 16'sd0}),
            tick_row_chk(5'b00100, t_out'{EV_NONE, 1'b0, 16'sd0}),
            tick_row(5'b00100, 45),
            tick_row(5'b00000, 1),
            tick_row(5'b00000, 1001),   // held past long press
            tick_row(5'b00100, 1),      // release after long press, no click
            tick_row(5'b00110, 1),
            cfg_row(16'd0, 16'd3, 16'd2),
            tick_row(5'b00000, 1),
            tick_row(5'b00100, 4),      // single click
            tick_row(5'b00110, 1),
            tick_row(5'b00000, 1),
            tick_row(5'b00100, 1),
            tick_row(5'b00000, 1),
            tick_row(5'b00100, 4),      // double click
            tick_row(5'b00000, 1),
            tick_row(5'b00100, 1),
            tick_row(5'b00000, 1),
            tick_row(5'b00100, 1),
            tick_row(5'b00000, 1),
            tick_row(5'b00100, 1),
            tick_row(5'b00000, 1),
            tick_row(5'b00100, 4),      // four clicks, count saturates
            tick_row(5'b00000, 5),
            tick_row(5'b00100, 2),
            tick_row(5'b00000, 1),
            tick_row(5'b00101, 1),      // clear drops the counted click
            tick_row(5'b00100, 4)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].is_cfg) begin
                load_config(script[r].db, script[r].lp, script[r].dc);
            end else begin
                repeat (script[r].reps)
                    push_tick(script[r].pins, script[r].fixed, script[r].want);
            end
        end

        load_config(16'd2, 16'd12, 16'd6);
        run_phase(100);
        load_config(16'd0, 16'd0, 16'd0);
        run_phase(80);
        quiet_run = 1'b1;
        load_config(16'd5, 16'd30, 16'd15);
        run_phase(100);
        quiet_run = 1'b0;
        load_config(RST_DEBOUNCE, RST_LONG_PRESS, RST_DOUBLE_CLICK);
        run_phase(120);
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(70);
        load_config(16'd1, 16'd4, 16'hFFFF);
        run_phase(70);
        load_config(16'd0, 16'hFFFF, 16'd3);
        run_phase(80);
        load_config(16'd3, 16'd10, 16'd5);
        spin(1'b1, 20);
        spin(1'b0, 20);

        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
